// File: hdl/tgc_pkg.sv
package tgc_pkg;

    // fixed field widths
    localparam int CNT_W      = 2;
    localparam int TIME_W     = 32;
    localparam int GEST_W     = 3;
    localparam int TRAVEL_W   = 12;
    localparam int MINTIME_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // touch limit and pinch ratio 1.25 as squares 25/16
    localparam int MAX_TOUCHES = 2;
    localparam int PINCH_NUM   = 25;
    localparam int PINCH_DEN   = 16;

    // register reset values
    localparam logic [TRAVEL_W-1:0]  TRAVEL_RST  = TRAVEL_W'(45);
    localparam logic [MINTIME_W-1:0] MINTIME_RST = MINTIME_W'(30);

    // decoupling queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [GEST_W-1:0] {
        G_NONE      = 3'd0,
        G_TAP       = 3'd1,
        G_LEFT      = 3'd2,
        G_RIGHT     = 3'd3,
        G_UP        = 3'd4,
        G_DOWN      = 3'd5,
        G_PINCH_IN  = 3'd6,
        G_PINCH_OUT = 3'd7
    } t_gesture;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWIPE_TRAVEL = 1'b0,
        CFG_CONTACT_TIME = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic tracking;
    } t_back_stat;

endpackage

// File: hdl/tgc_in_if.sv
interface tgc_in_if #(
    parameter int COORD_BITS = 12
);
    import tgc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CNT_W-1:0]      finger_count;
    logic                  coords_ok;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;
    logic [TIME_W-1:0]     time_ms;

    modport source (
        output valid, finger_count, coords_ok, first_x, first_y, second_x, second_y, time_ms,
        input  ready
    );
    modport sink (
        input  valid, finger_count, coords_ok, first_x, first_y, second_x, second_y, time_ms,
        output ready
    );
endinterface

// File: hdl/tgc_out_if.sv
interface tgc_out_if;
    import tgc_pkg::*;

    logic              valid;
    logic              ready;
    logic [GEST_W-1:0] gesture;

    modport source (
        output valid, gesture,
        input  ready
    );
    modport sink (
        input  valid, gesture,
        output ready
    );
endinterface

// File: hdl/touch_gesture_classifier.sv
// touch gesture classifier: tap, four-way swipe and pinch from touch reports
//
// i_item carries one touch report per item (finger count, coords-valid flag,
// two points, millisecond timestamp); o_result returns exactly one item per
// report, a gesture code that is none except on the report that releases a
// contact. the config port writes the swipe travel threshold (index 0) and
// the minimum contact time (index 1) with a single-cycle write enable
// throughput: one report per cycle while the receiver takes results, set
// by the combinational tracking and classify logic of the back end and
// the two-deep queue ahead of it
// the front end squares the finger spacing and writes the queue; the back
// end pops one entry per cycle while its output register is free or taken
// when the receiver stalls, the result holds, the back end stops popping and
// the queue absorbs up to two reports before i_item.ready drops
// synchronous reset clears the queue, the output valid, the contact state
// and restores both config registers to their defaults
module touch_gesture_classifier #(
    parameter int COORD_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tgc_in_if.sink                             i_item,
    tgc_out_if.source                          o_result,
    input  logic                               i_cfg_we,
    input  tgc_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tgc_pkg::*;

    // queue entry: count, flag, first point, squared spacing, timestamp
    localparam int SQ_W    = 2 * COORD_BITS + 1;
    localparam int ENTRY_W = CNT_W + 1 + 2 * COORD_BITS + SQ_W + TIME_W;

    logic               w_push;
    logic               w_pop;
    logic [ENTRY_W-1:0] w_push_entry;
    logic [ENTRY_W-1:0] w_pop_entry;
    t_q_stat            w_q_stat;
    t_back_stat         w_back_stat;

    // front: clamp finger count and compute the squared two-finger spacing
    tgc_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_item   (i_item),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // short queue so front and back stall independently
    tgc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .i_pop   (w_pop),
        .o_data  (w_pop_entry),
        .o_stat  (w_q_stat)
    );

    // back: contact tracking, release classification, output register
    tgc_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_entry    (w_pop_entry),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_result   (o_result),
        .o_stat     (w_back_stat)
    );

    // queue status is never full and empty at once
    a_q_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue reports full and empty together");

    // an accepted item is in the queue on the next edge
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !w_q_stat.empty)
        else $error("accepted item missing from queue");

    // every pop produces a result on the next edge
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_stat.pop |=> o_result.valid)
        else $error("popped item gave no result");

    // a real gesture only appears once the contact has ended
    a_gesture_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.gesture != G_NONE) |-> !w_back_stat.tracking)
        else $error("gesture shown while contact still tracked");

endmodule

// File: hdl/tgc_front.sv
module tgc_front #(
    parameter int COORD_BITS = 12,
    parameter int ENTRY_W    = 2 + 1 + 2 * 12 + (2 * 12 + 1) + 32
) (
    tgc_in_if.sink              i_item,
    input  tgc_pkg::t_q_stat    i_q_stat,
    output logic                o_push,
    output logic [ENTRY_W-1:0]  o_entry
);
    import tgc_pkg::*;

    localparam int SQ_W = 2 * COORD_BITS + 1;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic                  ok;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SQ_W-1:0]       sq;
        logic [TIME_W-1:0]     now;
    } t_entry;

    logic [COORD_BITS-1:0]   w_adx;
    logic [COORD_BITS-1:0]   w_ady;
    logic [2*COORD_BITS-1:0] w_sqx;
    logic [2*COORD_BITS-1:0] w_sqy;
    t_entry                  w_entry;

    assign i_item.ready = !i_q_stat.full;
    assign o_push       = i_item.valid && !i_q_stat.full;

    // absolute spacing per axis, then the two squarings
    always_comb begin
        w_adx = (i_item.first_x >= i_item.second_x) ? i_item.first_x - i_item.second_x
                                                    : i_item.second_x - i_item.first_x;
        w_ady = (i_item.first_y >= i_item.second_y) ? i_item.first_y - i_item.second_y
                                                    : i_item.second_y - i_item.first_y;
        w_sqx = w_adx * w_adx;
        w_sqy = w_ady * w_ady;
    end

    always_comb begin
        // three fingers clamp to the touch limit
        if (i_item.finger_count > CNT_W'(MAX_TOUCHES)) begin
            w_entry.count = CNT_W'(MAX_TOUCHES);
        end else begin
            w_entry.count = i_item.finger_count;
        end
        w_entry.ok  = i_item.coords_ok;
        w_entry.x   = i_item.first_x;
        w_entry.y   = i_item.first_y;
        w_entry.sq  = SQ_W'(w_sqx) + SQ_W'(w_sqy);
        w_entry.now = i_item.time_ms;
    end

    assign o_entry = ENTRY_W'(w_entry);

endmodule

// File: hdl/tgc_queue.sv
module tgc_queue #(
    parameter int WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output tgc_pkg::t_q_stat   o_stat
);
    import tgc_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// File: hdl/tgc_back.sv
module tgc_back #(
    parameter int COORD_BITS = 12,
    parameter int ENTRY_W    = 2 + 1 + 2 * 12 + (2 * 12 + 1) + 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  tgc_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [ENTRY_W-1:0]                   i_entry,
    input  tgc_pkg::t_q_stat                     i_q_stat,
    output logic                                 o_pop,
    tgc_out_if.source                            o_result,
    output tgc_pkg::t_back_stat                  o_stat
);
    import tgc_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS + 1;
    localparam int SCL_W = SQ_W + 5;
    localparam int TRV_W = (COORD_BITS > TRAVEL_W) ? COORD_BITS : TRAVEL_W;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic                  ok;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SQ_W-1:0]       sq;
        logic [TIME_W-1:0]     now;
    } t_entry;

    t_entry w_e;

    logic [TRAVEL_W-1:0]   r_travel;
    logic [MINTIME_W-1:0]  r_min_time;

    logic                  r_tracking,   n_tracking;
    logic [TIME_W-1:0]     r_start_time, n_start_time;
    logic [COORD_BITS-1:0] r_start_x,    n_start_x;
    logic [COORD_BITS-1:0] r_start_y,    n_start_y;
    logic [COORD_BITS-1:0] r_last_x,     n_last_x;
    logic [COORD_BITS-1:0] r_last_y,     n_last_y;
    logic [CNT_W-1:0]      r_most,       n_most;
    logic                  r_got,        n_got;
    logic [SQ_W-1:0]       r_sp_start,   n_sp_start;
    logic [SQ_W-1:0]       r_sp_last,    n_sp_last;
    logic [SQ_W-1:0]       r_sp_min,     n_sp_min;
    logic [SQ_W-1:0]       r_sp_max,     n_sp_max;

    logic                  r_out_valid,  n_out_valid;
    t_gesture              r_gesture,    n_gesture;

    logic [TIME_W-1:0]     w_held;
    logic [SQ_W-1:0]       w_min_eff;
    logic                  w_grow;
    logic                  w_shrink;
    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [TRV_W-1:0]      w_adx;
    logic [TRV_W-1:0]      w_ady;
    logic [TRV_W-1:0]      w_trv;
    t_gesture              w_class;

    assign w_e   = t_entry'(i_entry);
    assign o_pop = !i_q_stat.empty && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel   <= TRAVEL_RST;
            r_min_time <= MINTIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SWIPE_TRAVEL: begin
                    r_travel <= i_cfg_data[TRAVEL_W-1:0];
                end
                CFG_CONTACT_TIME: begin
                    r_min_time <= i_cfg_data[MINTIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // release classification from the state held before this item
    always_comb begin
        w_held    = w_e.now - r_start_time;
        w_min_eff = (r_sp_min > SQ_W'(1)) ? r_sp_min : SQ_W'(1);
        w_grow    = SCL_W'(r_sp_max) * SCL_W'(PINCH_DEN) >= SCL_W'(r_sp_start) * SCL_W'(PINCH_NUM);
        w_shrink  = SCL_W'(r_sp_start) * SCL_W'(PINCH_DEN) >= SCL_W'(w_min_eff) * SCL_W'(PINCH_NUM);
        w_dx      = $signed({1'b0, r_last_x}) - $signed({1'b0, r_start_x});
        w_dy      = $signed({1'b0, r_last_y}) - $signed({1'b0, r_start_y});
        w_adx     = TRV_W'(w_dx[COORD_BITS] ? -w_dx : w_dx);
        w_ady     = TRV_W'(w_dy[COORD_BITS] ? -w_dy : w_dy);
        w_trv     = TRV_W'(r_travel);

        if (w_held < TIME_W'(r_min_time)) begin
            w_class = G_NONE;
        end else if (!r_got) begin
            w_class = G_TAP;
        end else if (r_most >= CNT_W'(MAX_TOUCHES) && r_sp_start > SQ_W'(1)
                     && (w_grow || w_shrink)) begin
            w_class = (r_sp_last >= r_sp_start) ? G_PINCH_OUT : G_PINCH_IN;
        end else if (w_adx >= w_trv || w_ady >= w_trv) begin
            if (w_adx >= w_ady) begin
                w_class = (w_dx > 0) ? G_RIGHT : G_LEFT;
            end else begin
                w_class = (w_dy > 0) ? G_DOWN : G_UP;
            end
        end else begin
            w_class = G_TAP;
        end
    end

    // contact tracking
    always_comb begin
        n_tracking   = r_tracking;
        n_start_time = r_start_time;
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        n_last_x     = r_last_x;
        n_last_y     = r_last_y;
        n_most       = r_most;
        n_got        = r_got;
        n_sp_start   = r_sp_start;
        n_sp_last    = r_sp_last;
        n_sp_min     = r_sp_min;
        n_sp_max     = r_sp_max;
        n_gesture    = G_NONE;

        if (w_e.count != '0) begin
            if (!r_tracking) begin
                n_tracking   = 1'b1;
                n_start_time = w_e.now;
                n_start_x    = w_e.x;
                n_start_y    = w_e.y;
                n_last_x     = w_e.x;
                n_last_y     = w_e.y;
                n_most       = '0;
                n_got        = 1'b0;
                n_sp_start   = '0;
                n_sp_min     = '0;
                n_sp_max     = '0;
            end
            if (w_e.ok) begin
                if (!n_got) begin
                    n_start_x = w_e.x;
                    n_start_y = w_e.y;
                    n_got     = 1'b1;
                end
                n_last_x = w_e.x;
                n_last_y = w_e.y;
            end
            if (w_e.count > n_most) begin
                n_most = w_e.count;
            end
            if (w_e.ok && w_e.count >= CNT_W'(MAX_TOUCHES)) begin
                // zero start spacing restarts the spread history
                if (n_sp_start == '0) begin
                    n_sp_start = w_e.sq;
                    n_sp_min   = w_e.sq;
                    n_sp_max   = w_e.sq;
                end
                n_sp_last = w_e.sq;
                if (w_e.sq < n_sp_min) begin
                    n_sp_min = w_e.sq;
                end
                if (w_e.sq > n_sp_max) begin
                    n_sp_max = w_e.sq;
                end
            end
        end else if (r_tracking) begin
            n_tracking = 1'b0;
            n_gesture  = w_class;
        end
    end

    always_comb begin
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking   <= 1'b0;
            r_start_time <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_most       <= '0;
            r_got        <= 1'b0;
            r_sp_start   <= '0;
            r_sp_last    <= '0;
            r_sp_min     <= '0;
            r_sp_max     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_tracking   <= n_tracking;
                r_start_time <= n_start_time;
                r_start_x    <= n_start_x;
                r_start_y    <= n_start_y;
                r_last_x     <= n_last_x;
                r_last_y     <= n_last_y;
                r_most       <= n_most;
                r_got        <= n_got;
                r_sp_start   <= n_sp_start;
                r_sp_last    <= n_sp_last;
                r_sp_min     <= n_sp_min;
                r_sp_max     <= n_sp_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_gesture <= n_gesture;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.gesture = r_gesture;
    assign o_stat.pop       = o_pop;
    assign o_stat.tracking  = r_tracking;

endmodule
